@@ sv/ptsu_pkg.sv @@
// Shared types, codes and sizes for the periodic timer scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptsu_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;
   localparam int MAX_RESULTS    = 16;

   localparam int MODE_W   = 2;
   localparam int FIELD_W  = 32;
   localparam int REP_W    = 16;
   localparam int TAG_W    = 8;
   localparam int SLOT_W   = 4;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   // request word layout
   localparam int NOW_LO    = 0;
   localparam int PERIOD_LO = NOW_LO + FIELD_W;
   localparam int REP_LO    = PERIOD_LO + FIELD_W;
   localparam int TAG_LO    = REP_LO + REP_W;
   localparam int SLOT_LO   = TAG_LO + TAG_W;
   localparam int REQ_BITS  = SLOT_LO + SLOT_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   // response word layout
   localparam int RSP_BITS   = STATUS_W + SLOT_W + TAG_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD  = 2'd0,
      MODE_DEL  = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_DEL   = 2'd1,
      KIND_FIRED = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK         = 2'd0,
      STS_FULL       = 2'd1,
      STS_NOT_IN_USE = 2'd2
   } status_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [SLOT_W-1:0] slot_id;
      logic [TAG_W-1:0]  fired_tag;
      logic              expired;
      logic              last;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/periodic_timer_scheduler_unit.sv @@
// Top level of the periodic timer scheduler: sequencer, slot flags and response stage.
`timescale 1ns / 1ps
`default_nettype none
// A bank of NUM_TIMERS timer slots driven by request words (tuser = mode):
// add takes the lowest free slot and sets its due time to now + period;
// delete frees a slot; tick fires every due timer once, earliest due first,
// ties to the lower slot, at most 16 per tick, each firing one response word
// with tlast on the final word of the request. Mode 3 is taken and dropped.
// One request is worked at a time, and req_tready is high only between
// requests. Timer rows sit in a single-port-read memory that is scanned one
// slot per cycle through one shared compare unit. Delete needs no search;
// add searches for the lowest free slot; a tick makes one full scan pass
// per fired timer plus, unless 16 have fired, one more pass to find that
// nothing else is due.
// A stalled response side holds the sequencer only when a word must be pushed.
// Times are TIME_BITS wide, wrap modulo 2^TIME_BITS and compare unsigned.
module periodic_timer_scheduler_unit #(
   parameter int NUM_TIMERS = ptsu_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS  = ptsu_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // now[31:0], period[63:32], repeat_count[79:64], tag[87:80], slot[91:88], zero pad
   input  logic [ptsu_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [ptsu_pkg::MODE_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], slot_id[5:2], fired_tag[13:6], expired[14], zero pad
   output logic [ptsu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind[1:0]
   output logic [ptsu_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                            rsp_tlast
);
   import ptsu_pkg::*;

   localparam int SB  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW  = SB + 1;
   localparam int SLW = (CW > SLOT_W) ? CW : SLOT_W;
   localparam int NW  = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [TIME_BITS-1:0] due;
      logic [TIME_BITS-1:0] period;
      logic [REP_W-1:0]     limit;
      logic [REP_W-1:0]     count;
      logic [TAG_W-1:0]     tag;
   } row_type;

   localparam int RW = $bits(row_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_DEL,
      S_SCAN,
      S_DECIDE,
      S_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] per_ff, per_in;
   logic [REP_W-1:0]     rep_ff, rep_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [NUM_TIMERS-1:0] in_use_ff, in_use_in;
   logic [NUM_TIMERS-1:0] done_ff, done_in;
   rsp_type              pend_ff, pend_in;
   logic                 pend_vld_ff, pend_vld_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_vld_ff, rsp_vld_in;

   // memory and compare unit hookup
   logic                 ram_we;
   logic [SB-1:0]        ram_waddr;
   row_type              ram_wdata;
   logic [SB-1:0]        ram_raddr;
   logic [RW-1:0]        ram_rdata;
   row_type              rd_row;
   logic                 pick_start;
   logic                 cand_vld;
   logic [SB-1:0]        eidx;
   logic                 pick_found;
   logic [SB-1:0]        best_idx;
   logic [RW-1:0]        best_bits;
   row_type              best_row;

   // shared time adder
   logic [TIME_BITS-1:0] add_a, add_b, add_sum;

   logic                 out_free;
   logic [SB-1:0]        cidx;
   logic [SLW-1:0]       slot_ext;
   logic [SB-1:0]        sidx;
   logic                 slot_live;
   logic [REP_W-1:0]     cnt_next;
   logic                 expire;

   assign rd_row   = row_type'(ram_rdata);
   assign best_row = row_type'(best_bits);

   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign cidx      = cnt_ff[SB-1:0];
   assign eidx      = SB'(cnt_ff - 1'b1);
   assign ram_raddr = cidx;
   assign slot_ext  = SLW'(slot_ff);
   assign sidx      = slot_ext[SB-1:0];
   assign slot_live = (slot_ext < SLW'(NUM_TIMERS)) && in_use_ff[sidx];

   assign add_a   = (state_ff == S_ADD) ? now_ff : best_row.due;
   assign add_b   = (state_ff == S_ADD) ? per_ff : best_row.period;
   assign add_sum = add_a + add_b;

   // slot 0 has no predecessor in the read pipe; the pass ends after slot N-1
   assign cand_vld = (state_ff == S_SCAN) && (cnt_ff != '0) && in_use_ff[eidx] &&
                     !done_ff[eidx] && (rd_row.due <= now_ff);

   assign cnt_next = best_row.count + 1'b1;
   assign expire   = (best_row.limit != '0) && (cnt_next >= best_row.limit);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      now_in      = now_ff;
      per_in      = per_ff;
      rep_in      = rep_ff;
      tag_in      = tag_ff;
      slot_in     = slot_ff;
      in_use_in   = in_use_ff;
      done_in     = done_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      ram_we      = 1'b0;
      ram_waddr   = best_idx;
      ram_wdata   = best_row;
      pick_start  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               now_in  = TIME_BITS'(req_tdata[NOW_LO +: FIELD_W]);
               per_in  = TIME_BITS'(req_tdata[PERIOD_LO +: FIELD_W]);
               rep_in  = req_tdata[REP_LO +: REP_W];
               tag_in  = req_tdata[TAG_LO +: TAG_W];
               slot_in = req_tdata[SLOT_LO +: SLOT_W];
               cnt_in  = '0;
               case (mode_type'(req_tuser))
                  MODE_ADD: begin
                     state_in = S_ADD;
                  end
                  MODE_DEL: begin
                     state_in = S_DEL;
                  end
                  MODE_TICK: begin
                     state_in    = S_SCAN;
                     n_in        = '0;
                     done_in     = '0;
                     pend_vld_in = 1'b0;
                     pick_start  = 1'b1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_ADD: begin
            if (cnt_ff == CW'(NUM_TIMERS)) begin
               if (out_free) begin
                  rsp_in = '{kind: KIND_ADD, status: STS_FULL, slot_id: '0,
                             fired_tag: '0, expired: 1'b0, last: 1'b1};
                  rsp_vld_in = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (!in_use_ff[cidx]) begin
               if (out_free) begin
                  ram_we          = 1'b1;
                  ram_waddr       = cidx;
                  ram_wdata       = '{due: add_sum, period: per_ff, limit: rep_ff,
                                      count: '0, tag: tag_ff};
                  in_use_in[cidx] = 1'b1;
                  rsp_in = '{kind: KIND_ADD, status: STS_OK, slot_id: SLOT_W'(cidx),
                             fired_tag: '0, expired: 1'b0, last: 1'b1};
                  rsp_vld_in = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_DEL: begin
            if (out_free) begin
               if (slot_live) begin
                  in_use_in[sidx] = 1'b0;
                  rsp_in = '{kind: KIND_DEL, status: STS_OK, slot_id: slot_ff,
                             fired_tag: '0, expired: 1'b0, last: 1'b1};
               end else begin
                  rsp_in = '{kind: KIND_DEL, status: STS_NOT_IN_USE, slot_id: slot_ff,
                             fired_tag: '0, expired: 1'b0, last: 1'b1};
               end
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end

         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NUM_TIMERS)) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            if (pick_found) begin
               // the held word is pushed here once another firing follows it, else later with tlast
               if (!pend_vld_ff || out_free) begin
                  if (pend_vld_ff) begin
                     rsp_in     = pend_ff;
                     rsp_vld_in = 1'b1;
                  end
                  ram_we    = 1'b1;
                  ram_waddr = best_idx;
                  ram_wdata = '{due: expire ? best_row.due : add_sum,
                                period: best_row.period,
                                limit: best_row.limit,
                                count: (best_row.limit != '0) ? cnt_next : best_row.count,
                                tag: best_row.tag};
                  if (expire) begin
                     in_use_in[best_idx] = 1'b0;
                  end
                  done_in[best_idx] = 1'b1;
                  pend_in = '{kind: KIND_FIRED, status: STS_OK,
                              slot_id: SLOT_W'(best_idx), fired_tag: best_row.tag,
                              expired: expire, last: 1'b0};
                  pend_vld_in = 1'b1;
                  n_in        = n_ff + 1'b1;
                  if (n_ff == NW'(MAX_RESULTS - 1)) begin
                     state_in = S_FLUSH;
                  end else begin
                     state_in   = S_SCAN;
                     cnt_in     = '0;
                     pick_start = 1'b1;
                  end
               end
            end else if (out_free) begin
               if (pend_vld_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = '{kind: KIND_IDLE, status: STS_OK, slot_id: '0,
                             fired_tag: '0, expired: 1'b0, last: 1'b1};
               end
               rsp_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
               rsp_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         in_use_ff   <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_use_ff   <= in_use_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      now_ff  <= now_in;
      per_ff  <= per_in;
      rep_ff  <= rep_in;
      tag_ff  <= tag_in;
      slot_ff <= slot_in;
      done_ff <= done_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   ptsu_ram #(
      .DEPTH (NUM_TIMERS),
      .WIDTH (RW),
      .AW    (SB)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ptsu_pick #(
      .IDX_W (SB),
      .KEY_W (TIME_BITS),
      .ROW_W (RW)
   ) u_pick (
      .clock    (clock),
      .reset    (reset),
      .start    (pick_start),
      .cand_vld (cand_vld),
      .cand_idx (eidx),
      .cand_key (rd_row.due),
      .cand_row (ram_rdata),
      .found    (pick_found),
      .best_idx (best_idx),
      .best_row (best_bits)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.expired, rsp_ff.fired_tag,
                        rsp_ff.slot_id, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule
`default_nettype wire

@@ sv/ptsu_ram.sv @@
// Timer row memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ptsu_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 104,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/ptsu_pick.sv @@
// Shared compare unit: keeps the earliest eligible timer seen in one scan pass.
`timescale 1ns / 1ps
`default_nettype none
module ptsu_pick #(
   parameter int IDX_W = 4,
   parameter int KEY_W = 32,
   parameter int ROW_W = 104
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             cand_vld,
   input  logic [IDX_W-1:0] cand_idx,
   input  logic [KEY_W-1:0] cand_key,
   input  logic [ROW_W-1:0] cand_row,
   output logic             found,
   output logic [IDX_W-1:0] best_idx,
   output logic [ROW_W-1:0] best_row
);

   logic             found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [KEY_W-1:0] best_key_ff;
   logic [ROW_W-1:0] best_row_ff;
   logic             take;

   // strict less: slots arrive in ascending order, so ties keep the lower slot
   assign take = cand_vld && (!found_ff || (cand_key < best_key_ff));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= cand_idx;
         best_key_ff <= cand_key;
         best_row_ff <= cand_row;
      end
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;
   assign best_row = best_row_ff;

endmodule
`default_nettype wire
